/* hw/rtl/pss_pkg.sv */
// Shared types and constants for the periodic slot scheduler.
// No dependencies; imported by every module of the block.
package pss_pkg;

  localparam int NUM_SLOTS    = 16;
  localparam int SLOT_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int MAX_FIRES    = 16;
  localparam int FIRE_W       = $clog2(MAX_FIRES + 1);
  localparam int TIME_W       = 32;
  localparam int HANDLE_W     = 16;
  localparam int PERIOD_W     = 16;
  localparam int DIV_CNT_W    = $clog2(TIME_W + 1);
  localparam logic [TIME_W-1:0]   NEAR_HORIZON = 32'd1000;
  localparam logic [PERIOD_W:0]   MISS_SLACK   = 17'd2;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd20;

  typedef enum logic [1:0] {
    REQ_ATTACH = 2'd0,
    REQ_DETACH = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    KIND_FIRE        = 3'd0,
    KIND_ATTACH_OK   = 3'd1,
    KIND_ATTACH_FULL = 3'd2,
    KIND_DETACH_OK   = 3'd3,
    KIND_DETACH_MISS = 3'd4,
    KIND_SUMMARY     = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_RESP,
    S_TCHK,
    S_TDIV,
    S_TFIRE,
    S_TSUM
  } state_t;

  typedef struct packed {
    logic load;
    logic idx_clr;
    logic idx_inc;
    logic srch;
    logic resp;
    logic near;
    logic div_start;
    logic div_step;
    logic service;
    logic sum;
  } pss_cmd_t;

  typedef struct packed {
    req_t req_type;
    logic idx_last;
    logic cur_used;
    logic cur_due;
    logic div_done;
    logic out_free;
    logic fire_ok;
  } pss_status_t;

endpackage

/* hw/rtl/pss_ctrl.sv */
// Sequencer of the periodic slot scheduler.
// Depends on pss_pkg; drives pss_datapath through command and status structs.
module pss_ctrl
  import pss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  pss_status_t sts,
  output pss_cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          cmd.idx_clr = 1'b1;
          state_nxt   = S_SRCH;
        end
      end
      S_SRCH: begin
        // first cycle after load decides the request class
        case (sts.req_type)
          REQ_ATTACH, REQ_DETACH: begin
            cmd.srch = 1'b1;
            if (sts.idx_last) begin
              state_nxt = S_RESP;
            end else begin
              cmd.idx_inc = 1'b1;
            end
          end
          REQ_TICK: state_nxt = S_TCHK;
          default:  state_nxt = S_IDLE;
        endcase
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.resp  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_TCHK: begin
        if (sts.cur_used && sts.cur_due) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_TDIV;
        end else begin
          cmd.near = sts.cur_used;
          if (sts.idx_last) begin
            state_nxt = S_TSUM;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      S_TDIV: begin
        if (sts.div_done) begin
          state_nxt = S_TFIRE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_TFIRE: begin
        if (!sts.fire_ok || sts.out_free) begin
          cmd.service = 1'b1;
          if (sts.idx_last) begin
            state_nxt = S_TSUM;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_TCHK;
          end
        end
      end
      S_TSUM: begin
        if (sts.out_free) begin
          cmd.sum   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* hw/rtl/pss_datapath.sv */
// Slot table, remainder divider, period register and output word register.
// Depends on pss_pkg; commanded by pss_ctrl.
module pss_datapath
  import pss_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  pss_cmd_t            cmd,
  output pss_status_t         sts,
  input  logic [1:0]          in_req_type,
  input  logic [HANDLE_W-1:0] in_client_handle,
  input  logic [TIME_W-1:0]   in_now_ms,
  input  logic                in_updates_allowed,
  input  logic                cfg_valid,
  input  logic [PERIOD_W-1:0] cfg_period_ms,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_kind,
  output logic [3:0]          out_slot_index,
  output logic [HANDLE_W-1:0] out_client_handle_out,
  output logic [TIME_W-1:0]   out_elapsed_ms,
  output logic                out_deadline_miss,
  output logic [TIME_W-1:0]   out_nearest_due_ms,
  output logic                out_last
);

  logic [PERIOD_W-1:0] period_r;
  logic [NUM_SLOTS-1:0] used_r;
  logic [HANDLE_W-1:0] client_r [NUM_SLOTS];
  logic [TIME_W-1:0]   due_r    [NUM_SLOTS];
  logic [TIME_W-1:0]   lastc_r  [NUM_SLOTS];

  req_t                req_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [TIME_W-1:0]   now_r;
  logic                allow_r;
  logic [SLOT_W-1:0]   idx_r;
  logic                match_r, free_r;
  logic [SLOT_W-1:0]   match_idx_r, free_idx_r;
  logic [TIME_W-1:0]   nearest_r;
  logic                miss_r;
  logic [FIRE_W-1:0]   fires_r;
  logic [PERIOD_W-1:0] rem_r;
  logic [TIME_W-1:0]   dvd_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic                out_valid_r, out_valid_nxt;

  logic [HANDLE_W-1:0] cur_client;
  logic [TIME_W-1:0]   cur_due, cur_last, dt, new_due, cand;
  logic [PERIOD_W:0]   rem_sh;
  logic                rem_ge;
  logic                late;
  logic                resp_ok;
  logic [SLOT_W-1:0]   resp_idx;
  logic                out_free;

  // true when a - b is negative as a signed 32-bit value
  function automatic logic is_before(input logic [TIME_W-1:0] a,
                                     input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] diff;
    diff = a - b;
    return diff[TIME_W-1];
  endfunction

  assign cur_client = client_r[idx_r];
  assign cur_due    = due_r[idx_r];
  assign cur_last   = lastc_r[idx_r];
  assign dt         = now_r - cur_last;
  assign late       = {1'b0, dt} > {{(TIME_W - PERIOD_W){1'b0}}, {1'b0, period_r} + MISS_SLACK};
  // due moves to now - (now - due) mod period + period
  assign new_due    = now_r - {{(TIME_W - PERIOD_W){1'b0}}, rem_r}
                      + {{(TIME_W - PERIOD_W){1'b0}}, period_r};
  assign cand       = cmd.service ? new_due : cur_due;
  assign rem_sh     = {rem_r, dvd_r[TIME_W-1]};
  assign rem_ge     = rem_sh >= {1'b0, period_r};
  assign out_free   = !out_valid_r || !out_stall;

  always_comb begin
    if (req_r == REQ_ATTACH) begin
      resp_ok  = match_r || free_r;
      resp_idx = match_r ? match_idx_r : free_idx_r;
    end else begin
      resp_ok  = match_r;
      resp_idx = match_idx_r;
    end
  end

  assign sts.req_type = req_r;
  assign sts.idx_last = (idx_r == SLOT_W'(NUM_SLOTS - 1));
  assign sts.cur_used = used_r[idx_r];
  assign sts.cur_due  = !(is_before(now_r, cur_due));
  assign sts.div_done = (div_cnt_r == DIV_CNT_W'(TIME_W));
  assign sts.out_free = out_free;
  assign sts.fire_ok  = allow_r && (fires_r < FIRE_W'(MAX_FIRES));

  // hold the word while stalled, load a new one on any output command
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.resp || cmd.sum || (cmd.service && sts.fire_ok)) out_valid_nxt = 1'b1;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= PERIOD_RESET;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && (cfg_period_ms != '0)) period_r <= cfg_period_ms;
      out_valid_r <= out_valid_nxt;
      if (cmd.resp && resp_ok) used_r[resp_idx] <= (req_r == REQ_ATTACH);
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r     <= req_t'(in_req_type);
      handle_r  <= in_client_handle;
      now_r     <= in_now_ms;
      allow_r   <= in_updates_allowed;
      match_r   <= 1'b0;
      free_r    <= 1'b0;
      nearest_r <= in_now_ms + NEAR_HORIZON;
      miss_r    <= 1'b0;
      fires_r   <= '0;
    end
    if (cmd.idx_clr) idx_r <= '0;
    if (cmd.idx_inc) idx_r <= idx_r + 1'b1;
    if (cmd.srch) begin
      if (!match_r && used_r[idx_r] && (cur_client == handle_r)) begin
        match_r     <= 1'b1;
        match_idx_r <= idx_r;
      end
      if (!free_r && !used_r[idx_r]) begin
        free_r     <= 1'b1;
        free_idx_r <= idx_r;
      end
    end
    if (cmd.div_start) begin
      rem_r     <= '0;
      dvd_r     <= now_r - cur_due;
      div_cnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r     <= rem_ge ? PERIOD_W'(rem_sh - {1'b0, period_r}) : PERIOD_W'(rem_sh);
      dvd_r     <= {dvd_r[TIME_W-2:0], 1'b0};
      div_cnt_r <= div_cnt_r + 1'b1;
    end
    if ((cmd.near || cmd.service) && is_before(cand, nearest_r)) begin
      nearest_r <= cand;
    end
    if (cmd.service) begin
      if (late) miss_r <= 1'b1;
      lastc_r[idx_r] <= now_r;
      due_r[idx_r]   <= new_due;
      if (sts.fire_ok) begin
        fires_r               <= fires_r + 1'b1;
        out_kind              <= KIND_FIRE;
        out_slot_index        <= 4'(idx_r);
        out_client_handle_out <= cur_client;
        out_elapsed_ms        <= dt;
        out_deadline_miss     <= 1'b0;
        out_nearest_due_ms    <= '0;
        out_last              <= 1'b0;
      end
    end
    if (cmd.resp) begin
      if (resp_ok) begin
        if (req_r == REQ_ATTACH) begin
          client_r[resp_idx] <= handle_r;
          lastc_r[resp_idx]  <= now_r;
          due_r[resp_idx]    <= now_r + {{(TIME_W - PERIOD_W){1'b0}}, period_r};
          out_kind           <= KIND_ATTACH_OK;
        end else begin
          client_r[resp_idx] <= '0;
          lastc_r[resp_idx]  <= '0;
          due_r[resp_idx]    <= '0;
          out_kind           <= KIND_DETACH_OK;
        end
        out_slot_index <= 4'(resp_idx);
      end else begin
        out_kind       <= (req_r == REQ_ATTACH) ? KIND_ATTACH_FULL : KIND_DETACH_MISS;
        out_slot_index <= '0;
      end
      out_client_handle_out <= handle_r;
      out_elapsed_ms        <= '0;
      out_deadline_miss     <= 1'b0;
      out_nearest_due_ms    <= '0;
      out_last              <= 1'b1;
    end
    if (cmd.sum) begin
      out_kind              <= KIND_SUMMARY;
      out_slot_index        <= '0;
      out_client_handle_out <= '0;
      out_elapsed_ms        <= '0;
      out_deadline_miss     <= miss_r;
      out_nearest_due_ms    <= nearest_r;
      out_last              <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* hw/rtl/periodic_slot_scheduler.sv */
// Periodic slot scheduler: attach/detach clients to a slot table, tick-scan for due slots.
// Attach/detach: one search pass over the table, then the response word.
// Tick: one pass over the table, with the 32-step remainder divider run for each due slot.
// Throughput: one request at a time; in_stall stays high until its last word is queued.
// Reset: rst_n synchronous active low; clears all slots, period to 20 ms, output empty.
// Depends on pss_pkg, pss_ctrl and pss_datapath.
module periodic_slot_scheduler
  import pss_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // request words
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_req_type,
  input  logic [HANDLE_W-1:0] in_client_handle,
  input  logic [TIME_W-1:0]   in_now_ms,
  input  logic                in_updates_allowed,
  // result words
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_kind,
  output logic [3:0]          out_slot_index,
  output logic [HANDLE_W-1:0] out_client_handle_out,
  output logic [TIME_W-1:0]   out_elapsed_ms,
  output logic                out_deadline_miss,
  output logic [TIME_W-1:0]   out_nearest_due_ms,
  output logic                out_last,
  // period register write
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [PERIOD_W-1:0] cfg_period_ms
);

  pss_cmd_t    cmd;
  pss_status_t sts;

  // period register always takes the write; zero is dropped in the datapath
  assign cfg_ready = 1'b1;

  pss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pss_datapath u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_req_type           (in_req_type),
    .in_client_handle      (in_client_handle),
    .in_now_ms             (in_now_ms),
    .in_updates_allowed    (in_updates_allowed),
    .cfg_valid             (cfg_valid),
    .cfg_period_ms         (cfg_period_ms),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_kind              (out_kind),
    .out_slot_index        (out_slot_index),
    .out_client_handle_out (out_client_handle_out),
    .out_elapsed_ms        (out_elapsed_ms),
    .out_deadline_miss     (out_deadline_miss),
    .out_nearest_due_ms    (out_nearest_due_ms),
    .out_last              (out_last)
  );

endmodule
